// ===== sv/packet_header_metrics_extractor_core_macros.svh =====
// assertion macros for the packet header metrics extractor
// expects clk and rst in scope of the including module
`ifndef PACKET_HEADER_METRICS_EXTRACTOR_CORE_MACROS_SVH
`define PACKET_HEADER_METRICS_EXTRACTOR_CORE_MACROS_SVH

// checked only outside reset
`define PHME_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define PHME_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/phme_pkg.sv =====
// shared types and constants for the packet header metrics extractor
// no dependencies
package phme_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // header offsets fit in a 7 bit window
  localparam int OFF_W = 7;
  localparam logic [OFF_W-1:0] OFF_ETYPE_HI = 7'd12;
  localparam logic [OFF_W-1:0] OFF_ETYPE_LO = 7'd13;
  localparam logic [OFF_W-1:0] OFF_ETH_END  = 7'd14;
  localparam logic [OFF_W-1:0] OFF_V4_PROTO = 7'd23;
  localparam logic [OFF_W-1:0] OFF_V4_SRC   = 7'd26;
  localparam logic [OFF_W-1:0] OFF_V4_DST   = 7'd30;
  localparam logic [OFF_W-1:0] OFF_V4_L4    = 7'd34;
  localparam logic [OFF_W-1:0] OFF_V6_PROTO = 7'd20;
  localparam logic [OFF_W-1:0] OFF_V6_SRC   = 7'd22;
  localparam logic [OFF_W-1:0] OFF_V6_DST   = 7'd38;
  localparam logic [OFF_W-1:0] OFF_V6_L4    = 7'd54;
  localparam logic [OFF_W-1:0] L4_PORT_LEN  = 7'd4;
  localparam logic [OFF_W-1:0] L4_FLAGS     = 7'd13;
  localparam logic [OFF_W-1:0] TCP_HDR_LEN  = 7'd20;
  localparam logic [OFF_W-1:0] UDP_HDR_LEN  = 7'd8;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [63:0] time_ns;
  } phme_in_t;

  typedef struct packed {
    logic [15:0] packet_length;
    logic [63:0] stamp_ns;
    logic        ipv6_flag;
    logic [7:0]  l4_protocol;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
  } phme_rec_t;

  // one classified beat handed from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [63:0]      time_ns;
    logic [15:0]      len;
    logic [OFF_W-1:0] off;
    logic             in_hdr;
  } phme_beat_t;

  typedef struct packed {
    logic       valid;
    phme_beat_t beat;
  } phme_head_t;

endpackage

// ===== sv/phme_front.sv =====
// front end: accepts frame bytes, counts position and tags each beat
// depends on phme_pkg
module phme_front import phme_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pkt_valid,
  output logic       pkt_stall,
  input  phme_in_t   pkt,
  input  logic       q_full,
  output logic       push,
  output phme_beat_t beat
);

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  logic [LENGTH_BITS-1:0] pos;
  logic [LENGTH_BITS-1:0] pos_next;
  logic [LENGTH_BITS-1:0] len_full;
  logic [15:0]            len16;

  assign pkt_stall = q_full;
  assign push      = pkt_valid & ~q_full;

  // counter saturates at its top value
  assign len_full = (pos == CNT_MAX) ? pos : pos + 1'b1;

  if (LENGTH_BITS > 16) begin : g_sat
    assign len16 = (|len_full[LENGTH_BITS-1:16]) ? 16'hFFFF : len_full[15:0];
  end else begin : g_ext
    assign len16 = 16'(len_full);
  end

  always_comb begin
    beat.data    = pkt.packet_byte;
    beat.last    = pkt.last_byte;
    beat.time_ns = pkt.time_ns;
    beat.len     = len16;
    beat.off     = pos[OFF_W-1:0];
    beat.in_hdr  = ~|pos[LENGTH_BITS-1:OFF_W];
    pos_next     = pos;
    if (push) begin
      pos_next = pkt.last_byte ? '0 : len_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

// ===== sv/phme_queue.sv =====
// short fifo of tagged beats between front and back
// depends on phme_pkg
module phme_queue import phme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  phme_beat_t beat,
  input  logic       pop,
  output logic       full,
  output phme_head_t head
);

  phme_beat_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.beat  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/phme_back.sv =====
// back end: captures header fields per beat and builds the metrics record
// depends on phme_pkg
module phme_back import phme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  phme_head_t head,
  output logic       pop,
  output logic       rec_valid,
  input  logic       rec_stall,
  output phme_rec_t  rec
);

  logic [15:0] kind, kind_next;
  logic [7:0]  proto, proto_next;
  logic [63:0] src_hi, src_hi_next, src_lo, src_lo_next;
  logic [63:0] dst_hi, dst_hi_next, dst_lo, dst_lo_next;
  logic [31:0] ports, ports_next;
  logic [7:0]  flags, flags_next;
  logic [63:0] tstamp, tstamp_next;

  logic             out_free;
  logic             emit;
  logic             is_v4;
  logic             is_v6;
  logic             is_tcp;
  logic             is_udp;
  logic [OFF_W-1:0] l4_base;
  logic [OFF_W-1:0] needed;
  logic [OFF_W-1:0] off;
  logic [7:0]       b;
  phme_rec_t        rec_next;

  assign out_free = ~rec_valid | ~rec_stall;
  assign pop      = head.valid & (~head.beat.last | out_free);
  assign off      = head.beat.off;
  assign b        = head.beat.data;

  always_comb begin
    kind_next   = kind;
    proto_next  = proto;
    src_hi_next = src_hi;
    src_lo_next = src_lo;
    dst_hi_next = dst_hi;
    dst_lo_next = dst_lo;
    ports_next  = ports;
    flags_next  = flags;
    tstamp_next = tstamp;
    is_v4       = (kind == ETYPE_IPV4);
    is_v6       = (kind == ETYPE_IPV6);
    is_tcp      = (proto == PROTO_TCP);
    is_udp      = (proto == PROTO_UDP);
    l4_base     = is_v6 ? OFF_V6_L4 : OFF_V4_L4;

    if (head.beat.in_hdr) begin
      if (off == OFF_ETYPE_HI || off == OFF_ETYPE_LO) begin
        kind_next = {kind[7:0], b};
      end
      if (off == OFF_ETYPE_LO) begin
        tstamp_next = head.beat.time_ns;
      end
      // ethertype is settled by the time these offsets arrive
      if (off >= OFF_ETH_END) begin
        if (is_v4) begin
          if (off == OFF_V4_PROTO) begin
            proto_next = b;
          end else if (off >= OFF_V4_SRC && off < OFF_V4_DST) begin
            src_lo_next = {32'h0, src_lo[23:0], b};
          end else if (off >= OFF_V4_DST && off < OFF_V4_L4) begin
            dst_lo_next = {32'h0, dst_lo[23:0], b};
          end
        end else if (is_v6) begin
          if (off == OFF_V6_PROTO) begin
            proto_next = b;
          end else if (off >= OFF_V6_SRC && off < OFF_V6_SRC + 7'd8) begin
            src_hi_next = {src_hi[55:0], b};
          end else if (off >= OFF_V6_SRC + 7'd8 && off < OFF_V6_DST) begin
            src_lo_next = {src_lo[55:0], b};
          end else if (off >= OFF_V6_DST && off < OFF_V6_DST + 7'd8) begin
            dst_hi_next = {dst_hi[55:0], b};
          end else if (off >= OFF_V6_DST + 7'd8 && off < OFF_V6_L4) begin
            dst_lo_next = {dst_lo[55:0], b};
          end
        end
        if ((is_v4 || is_v6) && (is_tcp || is_udp)) begin
          if (off >= l4_base && off < l4_base + L4_PORT_LEN) begin
            ports_next = {ports[23:0], b};
          end
          if (is_tcp && off == l4_base + L4_FLAGS) begin
            flags_next = b;
          end
        end
      end
    end

    // minimum frame length for a record, from the state after this beat
    if (kind_next == ETYPE_IPV4 || kind_next == ETYPE_IPV6) begin
      needed = (kind_next == ETYPE_IPV6) ? OFF_V6_L4 : OFF_V4_L4;
      if (proto_next == PROTO_TCP) begin
        needed = needed + TCP_HDR_LEN;
      end else if (proto_next == PROTO_UDP) begin
        needed = needed + UDP_HDR_LEN;
      end
    end else begin
      needed = OFF_ETH_END;
    end
    emit = ~(head.beat.len < {9'h0, needed});

    rec_next.packet_length    = head.beat.len;
    rec_next.stamp_ns         = tstamp_next;
    rec_next.ipv6_flag        = (kind_next == ETYPE_IPV6);
    rec_next.l4_protocol      = (kind_next == ETYPE_IPV4 || kind_next == ETYPE_IPV6) ?
                                proto_next : 8'h0;
    rec_next.source_addr_high = src_hi_next;
    rec_next.source_addr_low  = src_lo_next;
    rec_next.dest_addr_high   = dst_hi_next;
    rec_next.dest_addr_low    = dst_lo_next;
    rec_next.source_port      = ports_next[31:16];
    rec_next.dest_port        = ports_next[15:0];
    rec_next.tcp_flag_bits    = flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind   <= '0;
      proto  <= '0;
      src_hi <= '0;
      src_lo <= '0;
      dst_hi <= '0;
      dst_lo <= '0;
      ports  <= '0;
      flags  <= '0;
      tstamp <= '0;
    end else if (pop) begin
      if (head.beat.last) begin
        // frame done, back to the reset state
        kind   <= '0;
        proto  <= '0;
        src_hi <= '0;
        src_lo <= '0;
        dst_hi <= '0;
        dst_lo <= '0;
        ports  <= '0;
        flags  <= '0;
        tstamp <= '0;
      end else begin
        kind   <= kind_next;
        proto  <= proto_next;
        src_hi <= src_hi_next;
        src_lo <= src_lo_next;
        dst_hi <= dst_hi_next;
        dst_lo <= dst_lo_next;
        ports  <= ports_next;
        flags  <= flags_next;
        tstamp <= tstamp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (out_free) begin
      rec_valid <= pop & head.beat.last & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pop && head.beat.last) begin
      rec <= rec_next;
    end
  end

endmodule

// ===== sv/packet_header_metrics_extractor_core.sv =====
// Packet header metrics extractor. Frame bytes enter one per beat on the pkt
// channel, with a last-byte mark and the current time; a metrics record leaves
// on the rec channel after the last byte of each frame long enough to hold the
// headers it names, and nothing leaves for a frame cut short. The block takes
// one byte per clock while pkt_stall is low: the front end tags each byte with
// its frame offset, a four-entry queue carries it to the back end, which captures
// fields and loads the record register. A record is written to the record register
// when its last byte leaves the queue; a stalled record stops the back end only
// on the next last byte, so the queue fills with that byte and up to three more
// behind it before pkt_stall rises. Frame length saturates at 65535 or at
// 2^LENGTH_BITS-1 if that is smaller, the internal count at 2^LENGTH_BITS-1.
module packet_header_metrics_extractor_core import phme_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pkt_valid,
  output logic      pkt_stall,
  input  phme_in_t  pkt,
  output logic      rec_valid,
  input  logic      rec_stall,
  output phme_rec_t rec
);

  `include "packet_header_metrics_extractor_core_macros.svh"

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_last_pop;
  phme_beat_t q_beat;
  phme_head_t q_head;

  phme_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt      (pkt),
    .q_full   (q_full),
    .push     (q_push),
    .beat     (q_beat)
  );

  phme_queue u_queue (
    .clk (clk),
    .rst (rst),
    .push(q_push),
    .beat(q_beat),
    .pop (q_pop),
    .full(q_full),
    .head(q_head)
  );

  phme_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .pop      (q_pop),
    .rec_valid(rec_valid),
    .rec_stall(rec_stall),
    .rec      (rec)
  );

  assign q_last_pop = q_pop & q_head.beat.last;

  `PHME_ASSERT(a_pop_nonempty, q_pop |-> q_head.valid, "back end popped an empty queue")
  `PHME_ASSERT(a_rec_after_last, $rose(rec_valid) |-> $past(q_last_pop), "stray record")
  `PHME_ASSERT(a_no_push_when_full, q_full |-> !q_push, "push into a full queue")
  `PHME_ASSERT_ALWAYS(a_reset_idle, rst |=> !rec_valid, "record valid right after reset")

endmodule
